FILE: rtl/core/dmt_pkg.sv
// ============================================================================
// DALI Manchester transceiver package
// Shared types, codes and reset values of the bus master transceiver.
// ============================================================================
package dmt_pkg;

  // Receive byte storage depth
  localparam int DMT_RX_BYTES = 3;
  // Bytes that fit in the result item
  localparam int DMT_OUT_BYTES = 3;

  // Item kinds on the input channel
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_PIN  = 2'd1;
  localparam logic [1:0] ACT_SEND = 2'd2;

  // Link status codes
  localparam logic [1:0] ST_NOANSWER  = 2'd0;
  localparam logic [1:0] ST_WAITING   = 2'd1;
  localparam logic [1:0] ST_RECEIVING = 2'd2;
  localparam logic [1:0] ST_ANSWER    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_FRAME_BITS = 3'd0;
  localparam logic [2:0] REG_HB_MIN     = 3'd1;
  localparam logic [2:0] REG_HB_MAX     = 3'd2;
  localparam logic [2:0] REG_SEND_GAP   = 3'd3;
  localparam logic [2:0] REG_NO_ANSWER  = 3'd4;
  localparam logic [2:0] REG_STOP_GAP   = 3'd5;

  // Configuration reset values
  localparam logic [4:0]  RST_FRAME_BITS = 5'd16;
  localparam logic [15:0] RST_HB_MIN     = 16'd333;
  localparam logic [15:0] RST_HB_MAX     = 16'd500;
  localparam logic [7:0]  RST_SEND_GAP   = 8'd22;
  localparam logic [7:0]  RST_NO_ANSWER  = 8'd23;
  localparam logic [7:0]  RST_STOP_GAP   = 8'd4;

  // Transmitter reset frame and saturation limit of the tick and half-bit counters
  localparam logic [15:0] RST_TX_FRAME = 16'hFF00;
  localparam logic [7:0]  CNT_MAX      = 8'hFF;

  // Transmitter phases
  typedef enum logic [9:0] {
    TXP_IDLE    = 10'b00_0000_0001,
    TXP_START   = 10'b00_0000_0010,
    TXP_START_X = 10'b00_0000_0100,
    TXP_BIT     = 10'b00_0000_1000,
    TXP_BIT_X   = 10'b00_0001_0000,
    TXP_STOP1   = 10'b00_0010_0000,
    TXP_STOP1_X = 10'b00_0100_0000,
    TXP_STOP2   = 10'b00_1000_0000,
    TXP_STOP2_X = 10'b01_0000_0000,
    TXP_STOP3   = 10'b10_0000_0000
  } tx_phase_t;

  // Receiver phases
  typedef enum logic [2:0] {
    RXP_IDLE  = 3'b001,
    RXP_START = 3'b010,
    RXP_BIT   = 3'b100
  } rx_phase_t;

endpackage

FILE: rtl/core/dali_manchester_transceiver.sv
// ============================================================================
// DALI Manchester bus master transceiver
// Sends forward frames, decodes backward frames and tracks link status.
// ============================================================================
//
// Input items arrive on the s_axis channel. The tuser kind selects a
// half-bit tick, a receive pin change (level and microsecond timestamp) or
// a send request (16-bit forward frame). Every accepted item yields exactly
// one result item on m_axis carrying the transmitter drive level, the link
// status and, when a backward frame ended on that item, its bytes and flags.
//
// Each item is handled by the logic between the state registers and the
// output register; the result appears in the cycle after acceptance.
// The output register is the only buffer, so s_axis_tready drops while a
// result waits and m_axis_tready is low; else one item per cycle is taken.
//
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata,
// one per clock, by the user only while no item is in flight (unchecked).
// A synchronous reset restores the configuration defaults, releases the
// bus, sets the status to no answer and empties the output register.
//
module dali_manchester_transceiver #(
  parameter int RX_BYTES = dmt_pkg::DMT_RX_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [0] pin_level, [32:1] time_us, [48:33] send_frame, [55:49] zero
  input  logic [55:0] s_axis_tdata,
  // tuser: [1:0] action
  input  logic [1:0]  s_axis_tuser,
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [0] bus_drive, [2:1] link_status, [4:3] frame_byte_count,
  //        [28:5] frame_data, [31:29] zero
  output logic [31:0] m_axis_tdata,
  // tuser: [0] frame_valid, [1] frame_error
  output logic [1:0]  m_axis_tuser,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import dmt_pkg::*;

  localparam int OUT_BYTES = (RX_BYTES < DMT_OUT_BYTES) ? RX_BYTES : DMT_OUT_BYTES;

  // Configuration registers
  logic [4:0]  frame_bits;
  logic [15:0] half_bit_min_us;
  logic [15:0] half_bit_max_us;
  logic [7:0]  send_gap_ticks;
  logic [7:0]  no_answer_ticks;
  logic [7:0]  stop_gap_ticks;

  // Link state
  tx_phase_t   tx_phase, tx_phase_next;
  logic [4:0]  tx_bit_index, tx_bit_index_next;
  logic [15:0] tx_shift_frame, tx_shift_frame_next;
  logic        drive_low, drive_low_next;
  logic [7:0]  idle_ticks, idle_ticks_next;
  logic [1:0]  status_code, status_code_next;
  rx_phase_t   rx_phase, rx_phase_next;
  logic [7:0]  half_bit_count, half_bit_count_next;
  logic [7:0]  rx_bytes [RX_BYTES];
  logic [7:0]  rx_bytes_next [RX_BYTES];
  logic        last_pin_low, last_pin_low_next;
  logic [31:0] last_edge_time, last_edge_time_next;

  // Result of the current item
  logic        fvalid, ferr;
  logic [1:0]  fcount;
  logic [23:0] fdata;

  logic        s_fire;
  logic        pin_level;
  logic [31:0] time_us;
  logic [15:0] send_frame;
  logic [31:0] dt;
  logic        dt_in_te, dt_in_2te;
  logic        tx_bit;
  logic [4:0]  bit_index_inc;
  logic [6:0]  rx_bits;
  logic [3:0]  rx_len;
  logic [1:0]  take_count;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign pin_level  = s_axis_tdata[0];
  assign time_us    = s_axis_tdata[32:1];
  assign send_frame = s_axis_tdata[48:33];

  // Edge timing windows, durations taken modulo 2^32
  assign dt        = time_us - last_edge_time;
  assign dt_in_te  = ({16'd0, half_bit_min_us} <= dt) && (dt <= {16'd0, half_bit_max_us});
  assign dt_in_2te = ({15'd0, half_bit_min_us, 1'b0} <= dt) &&
                     (dt <= {15'd0, half_bit_max_us, 1'b0});

  // Current data bit of the forward frame, zero past bit 15
  assign tx_bit        = tx_bit_index[4] ? 1'b0 : tx_shift_frame[4'd15 - tx_bit_index[3:0]];
  assign bit_index_inc = tx_bit_index + 5'd1;

  // Per-item next-state and result logic
  always_comb begin
    tx_phase_next       = tx_phase;
    tx_bit_index_next   = tx_bit_index;
    tx_shift_frame_next = tx_shift_frame;
    drive_low_next      = drive_low;
    idle_ticks_next     = idle_ticks;
    status_code_next    = status_code;
    rx_phase_next       = rx_phase;
    half_bit_count_next = half_bit_count;
    rx_bytes_next       = rx_bytes;
    last_pin_low_next   = last_pin_low;
    last_edge_time_next = last_edge_time;
    fvalid     = 1'b0;
    ferr       = 1'b0;
    fcount     = 2'd0;
    fdata      = 24'd0;
    rx_bits    = half_bit_count[7:1];
    rx_len     = rx_bits[6:3];
    take_count = 2'd0;

    case (s_axis_tuser)
      ACT_TICK: begin
        if (idle_ticks != CNT_MAX) begin
          idle_ticks_next = idle_ticks + 8'd1;
        end
        case (tx_phase)
          TXP_IDLE: begin
            if (status_code != ST_ANSWER && status_code != ST_RECEIVING &&
                idle_ticks_next >= no_answer_ticks) begin
              status_code_next = ST_NOANSWER;
            end
          end
          TXP_START: begin
            if (idle_ticks_next >= send_gap_ticks) begin
              drive_low_next   = 1'b1;
              tx_phase_next    = TXP_START_X;
              status_code_next = ST_NOANSWER;
            end
          end
          TXP_START_X: begin
            drive_low_next    = 1'b0;
            tx_bit_index_next = 5'd0;
            tx_phase_next     = TXP_BIT;
          end
          TXP_BIT: begin
            drive_low_next = tx_bit;
            tx_phase_next  = TXP_BIT_X;
          end
          TXP_BIT_X: begin
            drive_low_next    = !tx_bit;
            tx_bit_index_next = bit_index_inc;
            tx_phase_next     = (bit_index_inc < frame_bits) ? TXP_BIT : TXP_STOP1;
          end
          TXP_STOP1: begin
            drive_low_next = 1'b0;
            tx_phase_next  = TXP_STOP1_X;
          end
          TXP_STOP1_X: tx_phase_next = TXP_STOP2;
          TXP_STOP2:   tx_phase_next = TXP_STOP2_X;
          TXP_STOP2_X: tx_phase_next = TXP_STOP3;
          TXP_STOP3: begin
            status_code_next = ST_WAITING;
            idle_ticks_next  = 8'd0;
            tx_phase_next    = TXP_IDLE;
            rx_phase_next    = RXP_IDLE;
          end
          default: tx_phase_next = TXP_IDLE;
        endcase
        // A quiet bus ends the backward frame
        if (rx_phase_next == RXP_BIT && idle_ticks_next > stop_gap_ticks) begin
          rx_phase_next    = RXP_IDLE;
          status_code_next = ST_ANSWER;
          fvalid           = 1'b1;
          if (rx_bits[2:0] != 3'd0 || {28'd0, rx_len} > RX_BYTES ||
              {28'd0, rx_len} > DMT_OUT_BYTES) begin
            ferr = 1'b1;
          end else begin
            fcount = rx_len[1:0];
            for (int k = 0; k < OUT_BYTES; k++) begin
              if (k < {28'd0, rx_len}) begin
                fdata[23 - 8 * k -: 8] = rx_bytes[k];
              end
            end
          end
        end
      end
      ACT_PIN: begin
        idle_ticks_next = 8'd0;
        if (tx_phase == TXP_IDLE && pin_level != last_pin_low) begin
          last_edge_time_next = time_us;
          last_pin_low_next   = pin_level;
          case (rx_phase)
            RXP_IDLE: begin
              if (!pin_level) begin
                rx_phase_next    = RXP_START;
                status_code_next = ST_RECEIVING;
              end
            end
            RXP_START: begin
              if (!pin_level || !dt_in_te) begin
                rx_phase_next = RXP_IDLE;
              end else begin
                half_bit_count_next = 8'd0;
                for (int i = 0; i < RX_BYTES; i++) begin
                  rx_bytes_next[i] = 8'd0;
                end
                rx_phase_next = RXP_BIT;
              end
            end
            RXP_BIT: begin
              if (dt_in_te) begin
                take_count = 2'd1;
              end else if (dt_in_2te) begin
                take_count = 2'd2;
              end else begin
                rx_phase_next    = RXP_IDLE;
                status_code_next = ST_NOANSWER;
              end
            end
            default: rx_phase_next = RXP_IDLE;
          endcase
          // Take one or two half-bits; the second half of each bit is the data
          for (int s = 0; s < 2; s++) begin
            if (s < {30'd0, take_count}) begin
              if (half_bit_count_next[0]) begin
                for (int i = 0; i < RX_BYTES; i++) begin
                  if ({28'd0, half_bit_count_next[7:4]} == i) begin
                    rx_bytes_next[i] = {rx_bytes_next[i][6:0], pin_level};
                  end
                end
              end
              if (half_bit_count_next != CNT_MAX) begin
                half_bit_count_next = half_bit_count_next + 8'd1;
              end
            end
          end
        end
      end
      ACT_SEND: begin
        tx_shift_frame_next = send_frame;
        tx_phase_next       = TXP_START;
        drive_low_next      = 1'b0;
      end
      default: begin
        // Unknown kind: state holds, result shows it
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits      <= RST_FRAME_BITS;
      half_bit_min_us <= RST_HB_MIN;
      half_bit_max_us <= RST_HB_MAX;
      send_gap_ticks  <= RST_SEND_GAP;
      no_answer_ticks <= RST_NO_ANSWER;
      stop_gap_ticks  <= RST_STOP_GAP;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_BITS: frame_bits      <= cfg_wdata[4:0];
        REG_HB_MIN:     half_bit_min_us <= cfg_wdata;
        REG_HB_MAX:     half_bit_max_us <= cfg_wdata;
        REG_SEND_GAP:   send_gap_ticks  <= cfg_wdata[7:0];
        REG_NO_ANSWER:  no_answer_ticks <= cfg_wdata[7:0];
        REG_STOP_GAP:   stop_gap_ticks  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // State update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_phase       <= TXP_IDLE;
      tx_bit_index   <= 5'd0;
      tx_shift_frame <= RST_TX_FRAME;
      drive_low      <= 1'b0;
      idle_ticks     <= 8'd0;
      status_code    <= ST_NOANSWER;
      rx_phase       <= RXP_IDLE;
      half_bit_count <= 8'd0;
      for (int i = 0; i < RX_BYTES; i++) begin
        rx_bytes[i] <= 8'd0;
      end
      last_pin_low   <= 1'b1;
      last_edge_time <= 32'd0;
    end else if (s_fire) begin
      tx_phase       <= tx_phase_next;
      tx_bit_index   <= tx_bit_index_next;
      tx_shift_frame <= tx_shift_frame_next;
      drive_low      <= drive_low_next;
      idle_ticks     <= idle_ticks_next;
      status_code    <= status_code_next;
      rx_phase       <= rx_phase_next;
      half_bit_count <= half_bit_count_next;
      rx_bytes       <= rx_bytes_next;
      last_pin_low   <= last_pin_low_next;
      last_edge_time <= last_edge_time_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_axis_tdata <= {3'd0, fdata, fcount, status_code_next, drive_low_next};
      m_axis_tuser <= {ferr, fvalid};
    end
  end

  // An accepted item always leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // The bus drive only moves when an item is accepted
  a_drive_stable: assert property (@(posedge clk) disable iff (rst)
    !s_fire |=> $stable(drive_low))
    else $error("bus drive changed without an item");

  // A backward frame can only end while bits are being received
  a_frame_end_in_bit: assert property (@(posedge clk) disable iff (rst)
    (s_fire && fvalid) |-> (rx_phase == RXP_BIT))
    else $error("frame ended outside bit reception");

  // An error frame carries no bytes
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    (s_fire && ferr) |=> (m_axis_tdata[28:3] == 26'd0))
    else $error("error frame carries data");

endmodule

FILE: bench/dali_manchester_transceiver_checker.sv
// ============================================================================
// DALI Manchester transceiver checker
// Watches the input, result and configuration channels of the transceiver.
// It keeps its own copy of the transmitter, receiver and link state, works
// out the result item that each accepted input item should cause, and
// compares every accepted result item, field by field, with the oldest
// expectation still waiting.
// ============================================================================
module dali_manchester_transceiver_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // tdata: [0] pin_level, [32:1] time_us, [48:33] send_frame, [55:49] zero
  input  logic [55:0] s_axis_tdata,
  // tuser: [1:0] action
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [0] bus_drive, [2:1] link_status, [4:3] frame_byte_count,
  //        [28:5] frame_data, [31:29] zero
  input  logic [31:0] m_axis_tdata,
  // tuser: [0] frame_valid, [1] frame_error
  input  logic [1:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);
  import dmt_pkg::*;

  // One result item as the transceiver should present it
  typedef struct packed {
    logic        bus_drive;
    logic [1:0]  link_status;
    logic        frame_valid;
    logic        frame_error;
    logic [1:0]  byte_count;
    logic [23:0] frame_data;
  } link_result_t;

  // Configuration copy
  logic [4:0]  cfg_bits;
  logic [15:0] te_min, te_max;
  logic [7:0]  gap_need, no_ans, stop_need;

  // Transmitter, link and receiver state copy
  tx_phase_t   tx_ph;
  logic [4:0]  tx_idx;
  logic [15:0] tx_word;
  logic        drive;
  logic [7:0]  idle_cnt;
  logic [1:0]  status;
  rx_phase_t   rx_ph;
  logic [7:0]  hb_cnt;
  logic [DMT_RX_BYTES-1:0][7:0] rx_byte;
  logic        last_low;
  logic [31:0] last_t;

  link_result_t link_results_due[$];
  link_result_t due_result, seen, oldest;
  int fail_count = 0;

  // Duration checks against the Te and 2Te windows
  function automatic logic within_te(input logic [31:0] dt);
    return ({16'd0, te_min} <= dt) && (dt <= {16'd0, te_max});
  endfunction

  function automatic logic within_2te(input logic [31:0] dt);
    return ({15'd0, te_min, 1'b0} <= dt) && (dt <= {15'd0, te_max, 1'b0});
  endfunction

  // Data bit of the forward frame at the current bit position, MSB first
  function automatic logic outgoing_bit();
    if (tx_idx >= 5'd16) return 1'b0;
    return tx_word[15 - int'(tx_idx)];
  endfunction

  // Every second half-bit carries a data bit; bytes past storage are dropped
  task automatic take_half_bit(input logic b);
    logic [7:0] pos;
    if (hb_cnt[0]) begin
      pos = (hb_cnt - 8'd1) >> 4;
      if (pos < DMT_RX_BYTES) rx_byte[pos] = {rx_byte[pos][6:0], b};
    end
    if (hb_cnt != CNT_MAX) hb_cnt++;
  endtask

  // Advance the state copy by one input item and give the result it causes
  task automatic step_transceiver(input logic [1:0] act, input logic pin,
                                  input logic [31:0] stamp, input logic [15:0] word,
                                  output link_result_t res);
    logic [31:0] dt;
    logic [6:0]  bits;
    logic [3:0]  len;
    int k;
    res = '0;
    case (act)
      ACT_TICK: begin
        if (idle_cnt != CNT_MAX) idle_cnt++;
        case (tx_ph)
          TXP_IDLE: begin
            if (status != ST_ANSWER && status != ST_RECEIVING && idle_cnt >= no_ans)
              status = ST_NOANSWER;
          end
          TXP_START: begin
            if (idle_cnt >= gap_need) begin
              drive = 1'b1;
              tx_ph = TXP_START_X;
              status = ST_NOANSWER;
            end
          end
          TXP_START_X: begin
            drive = 1'b0;
            tx_idx = '0;
            tx_ph = TXP_BIT;
          end
          TXP_BIT: begin
            drive = outgoing_bit();
            tx_ph = TXP_BIT_X;
          end
          TXP_BIT_X: begin
            drive = ~outgoing_bit();
            tx_idx = tx_idx + 5'd1;
            tx_ph = (tx_idx < cfg_bits) ? TXP_BIT : TXP_STOP1;
          end
          TXP_STOP1: begin
            drive = 1'b0;
            tx_ph = TXP_STOP1_X;
          end
          TXP_STOP1_X: tx_ph = TXP_STOP2;
          TXP_STOP2:   tx_ph = TXP_STOP2_X;
          TXP_STOP2_X: tx_ph = TXP_STOP3;
          TXP_STOP3: begin
            status = ST_WAITING;
            idle_cnt = '0;
            tx_ph = TXP_IDLE;
            rx_ph = RXP_IDLE;
          end
          default: tx_ph = TXP_IDLE;
        endcase
        // A quiet bus closes a backward frame
        if (rx_ph == RXP_BIT && idle_cnt > stop_need) begin
          bits = hb_cnt[7:1];
          len = bits[6:3];
          rx_ph = RXP_IDLE;
          status = ST_ANSWER;
          res.frame_valid = 1'b1;
          if (bits[2:0] != 3'd0 || len > DMT_RX_BYTES || len > DMT_OUT_BYTES) begin
            res.frame_error = 1'b1;
          end else begin
            res.byte_count = len[1:0];
            for (k = 0; k < len; k++)
              res.frame_data = res.frame_data | ({rx_byte[k], 16'd0} >> (8 * k));
          end
        end
      end
      ACT_PIN: begin
        idle_cnt = '0;
        if (tx_ph == TXP_IDLE && pin != last_low) begin
          dt = stamp - last_t;
          last_t = stamp;
          last_low = pin;
          case (rx_ph)
            RXP_IDLE: begin
              if (!pin) begin
                rx_ph = RXP_START;
                status = ST_RECEIVING;
              end
            end
            RXP_START: begin
              if (!pin || !within_te(dt)) begin
                rx_ph = RXP_IDLE;
              end else begin
                hb_cnt = '0;
                rx_byte = '0;
                rx_ph = RXP_BIT;
              end
            end
            RXP_BIT: begin
              if (within_te(dt)) begin
                take_half_bit(pin);
              end else if (within_2te(dt)) begin
                take_half_bit(pin);
                take_half_bit(pin);
              end else begin
                rx_ph = RXP_IDLE;
                status = ST_NOANSWER;
              end
            end
            default: rx_ph = RXP_IDLE;
          endcase
        end
      end
      ACT_SEND: begin
        tx_word = word;
        tx_ph = TXP_START;
        drive = 1'b0;
      end
      default: ;
    endcase
    res.bus_drive = drive;
    res.link_status = status;
  endtask

  // Compare results, predict new ones and follow register writes
  always @(posedge clk) begin
    if (rst) begin
      cfg_bits = RST_FRAME_BITS;
      te_min = RST_HB_MIN;
      te_max = RST_HB_MAX;
      gap_need = RST_SEND_GAP;
      no_ans = RST_NO_ANSWER;
      stop_need = RST_STOP_GAP;
      tx_ph = TXP_IDLE;
      tx_idx = '0;
      tx_word = RST_TX_FRAME;
      drive = 1'b0;
      idle_cnt = '0;
      status = ST_NOANSWER;
      rx_ph = RXP_IDLE;
      hb_cnt = '0;
      rx_byte = '0;
      last_low = 1'b1;
      last_t = '0;
      link_results_due.delete();
      pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.bus_drive = m_axis_tdata[0];
        seen.link_status = m_axis_tdata[2:1];
        seen.byte_count = m_axis_tdata[4:3];
        seen.frame_data = m_axis_tdata[28:5];
        seen.frame_valid = m_axis_tuser[0];
        seen.frame_error = m_axis_tuser[1];
        if (link_results_due.size() == 0) begin
          if (fail_count < 10)
            $display("mismatch at %0t: result item with none expected", $time);
          fail_count++;
        end else begin
          oldest = link_results_due.pop_front();
          if (seen.bus_drive !== oldest.bus_drive ||
              seen.link_status !== oldest.link_status ||
              seen.frame_valid !== oldest.frame_valid ||
              seen.frame_error !== oldest.frame_error ||
              seen.byte_count !== oldest.byte_count ||
              seen.frame_data !== oldest.frame_data) begin
            if (fail_count < 10) begin
              $display("mismatch at %0t: expected drive %0d status %0d valid %0d",
                       $time, oldest.bus_drive, oldest.link_status, oldest.frame_valid,
                       " error %0d bytes %0d data %06h", oldest.frame_error,
                       oldest.byte_count, oldest.frame_data);
              $display("  got drive %0d status %0d valid %0d error %0d bytes %0d data %06h",
                       seen.bus_drive, seen.link_status, seen.frame_valid,
                       seen.frame_error, seen.byte_count, seen.frame_data);
            end
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_transceiver(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[32:1],
                         s_axis_tdata[48:33], due_result);
        link_results_due.push_back(due_result);
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_FRAME_BITS: cfg_bits = cfg_wdata[4:0];
          REG_HB_MIN:     te_min = cfg_wdata;
          REG_HB_MAX:     te_max = cfg_wdata;
          REG_SEND_GAP:   gap_need = cfg_wdata[7:0];
          REG_NO_ANSWER:  no_ans = cfg_wdata[7:0];
          REG_STOP_GAP:   stop_need = cfg_wdata[7:0];
          default: ;
        endcase
      end
      pending <= link_results_due.size();
    end
    mismatches <= fail_count;
  end

endmodule

FILE: bench/dali_manchester_transceiver_tb.sv
// ============================================================================
// DALI Manchester transceiver testbench
// Drives ticks, receive pin edges and send requests into the transceiver
// through several register settings, with random gaps on both channels, and
// leaves prediction and comparison to the checker beside the block.
// ============================================================================
module dali_manchester_transceiver_tb;
  import dmt_pkg::*;

  // Item kind that the block does not know
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = ACT_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = REG_FRAME_BITS;
  logic [15:0] cfg_wdata = '0;
  int          mismatches;
  int          pending;

  // Register values in force, used to shape well-formed traffic
  logic [4:0]  fbits = RST_FRAME_BITS;
  logic [15:0] te_lo = RST_HB_MIN;
  logic [15:0] te_hi = RST_HB_MAX;
  logic [7:0]  gap_ticks = RST_SEND_GAP;
  logic [7:0]  noans_ticks = RST_NO_ANSWER;
  logic [7:0]  stop_ticks = RST_STOP_GAP;

  logic        pin_now = 1'b1;
  logic [31:0] now_us = '0;
  int          items_taken = 0;
  bit          steady = 1'b0;
  int          hold_off_asks = 0;

  dali_manchester_transceiver DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  dali_manchester_transceiver_checker watch (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Idle length for either side: mostly none, a few long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Random duration of the given number of half-bits within the window
  function automatic logic [31:0] half_bit_us(input int halves);
    logic [31:0] lo, hi;
    lo = 32'(te_lo) * halves;
    hi = 32'(te_hi) * halves;
    if (lo > hi) return lo;
    return $urandom_range(hi, lo);
  endfunction

  // Half-bit count of a backward frame: mostly whole bytes
  function automatic int frame_halves();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1);
      1, 2, 3, 4, 5, 6: return 16 * $urandom_range(1, 3) + $urandom_range(0, 1);
      7: return 16 * 4 + $urandom_range(0, 1);
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  // Offer one item after a random gap and wait until it is taken
  task automatic put_item(input logic [1:0] act, input logic pin,
                          input logic [31:0] stamp, input logic [15:0] word);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {7'd0, word, stamp, pin};
    do @(posedge clk); while (!s_axis_tready);
    items_taken++;
    if (act == ACT_PIN) begin
      now_us = stamp;
      pin_now = pin;
    end
  endtask

  task automatic ticks(input int n);
    repeat (n) put_item(ACT_TICK, 1'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic pin_edge(input logic level, input logic [31:0] dt);
    put_item(ACT_PIN, level, now_us + dt, 16'($urandom));
  endtask

  // Stop offering and wait until every expected result has come
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Backward frame: release, start half-bit, then data edges of Te or 2Te;
  // a spoiled frame gets one edge at a random time
  task automatic answer_frame(input int halves, input bit spoil);
    int left, step, spoil_at, quiet;
    spoil_at = (spoil && halves > 0) ? $urandom_range(1, halves) : -1;
    if (!pin_now) pin_edge(1'b1, half_bit_us(1));
    pin_edge(1'b0, $urandom_range(1000, 20000));
    pin_edge(1'b1, half_bit_us(1));
    left = halves;
    while (left > 0) begin
      step = (left >= 2 && $urandom_range(0, 1) == 1) ? 2 : 1;
      pin_edge(!pin_now, (left == spoil_at) ? $urandom : half_bit_us(step));
      left -= step;
    end
    quiet = (stop_ticks > 8'd24) ? 24 : int'(stop_ticks);
    ticks(quiet + 1 + $urandom_range(0, 3));
  endtask

  // Forward frame, sometimes disturbed, then an answer or silence
  task automatic exchange();
    int busy;
    busy = int'(gap_ticks) + 2 * ((fbits == 5'd0) ? 1 : int'(fbits)) + 8;
    put_item(ACT_SEND, 1'($urandom), $urandom, 16'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      ticks($urandom_range(1, 8));
      if ($urandom_range(0, 1) == 1)
        pin_edge(!pin_now, half_bit_us(1));
      else
        put_item(ACT_SEND, 1'($urandom), $urandom, 16'($urandom));
    end
    ticks(busy);
    if ($urandom_range(0, 4) != 0)
      answer_frame(frame_halves(), $urandom_range(0, 7) == 0);
    else
      ticks(((noans_ticks > 8'd30) ? 30 : int'(noans_ticks)) + 2);
  endtask

  // Mixed traffic until the item budget is used up
  task automatic run_activities(input int budget);
    int stop_at, roll;
    stop_at = items_taken + budget;
    while (items_taken < stop_at) begin
      steady = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 9);
      if (roll < 5)
        exchange();
      else if (roll < 7)
        answer_frame(frame_halves(), roll == 6);
      else if (roll < 9)
        repeat ($urandom_range(3, 12))
          put_item(2'($urandom), 1'($urandom), $urandom, 16'($urandom));
      else
        ticks($urandom_range(1, 20));
    end
    steady = 1'b0;
  endtask

  // New register setting on an idle block, then traffic
  task automatic run_phase(input logic [4:0] fb, input logic [15:0] lo, input logic [15:0] hi,
                           input logic [7:0] gap, input logic [7:0] noans,
                           input logic [7:0] stop, input int budget);
    wait_drained();
    fbits = fb;
    te_lo = lo;
    te_hi = hi;
    gap_ticks = gap;
    noans_ticks = noans;
    stop_ticks = stop;
    set_register(REG_FRAME_BITS, 16'(fb));
    set_register(REG_HB_MIN, lo);
    set_register(REG_HB_MAX, hi);
    set_register(REG_SEND_GAP, 16'(gap));
    set_register(REG_NO_ANSWER, 16'(noans));
    set_register(REG_STOP_GAP, 16'(stop));
    cfg_we <= 1'b0;
    run_activities(budget);
  endtask

  // Result side: random stalls, and one long hold-off on request
  initial begin
    int stall, served;
    stall = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_off_asks) begin
        served = hold_off_asks;
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        stall = idle_len();
        m_axis_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [15:0] lo_pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Unknown kind, unchanged pin level, sends while busy, extreme stamps
    put_item(ACT_UNUSED, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    put_item(ACT_PIN, 1'b1, 32'h0000_0000, 16'h0000);
    put_item(ACT_TICK, 1'b0, 32'h0000_0000, 16'h0000);
    put_item(ACT_SEND, 1'b0, 32'h0000_0000, 16'h0000);
    put_item(ACT_PIN, 1'b0, 32'h8000_0000, 16'h0000);
    put_item(ACT_SEND, 1'b1, 32'h7FFF_FFFF, 16'hFFFF);
    ticks(3);
    put_item(ACT_PIN, 1'b1, 32'hFFFF_FFFF, 16'hA5A5);
    ticks(int'(gap_ticks) + 2 * int'(fbits) + 8);

    // Backward frame long enough to saturate the half-bit counter
    answer_frame(270, 1'b0);

    // Long hold-off on the result side while items keep coming
    hold_off_asks++;
    steady = 1'b1;
    ticks(40);
    steady = 1'b0;
    wait_drained();
    run_activities(30);

    run_phase(5'd8, 16'd333, 16'd500, 8'd0, 8'd0, 8'd0, 20);
    run_phase(5'd0, 16'd0, 16'hFFFF, 8'd255, 8'd255, 8'd255, 10);
    // Timestamps cross the 32-bit wrap in this setting
    now_us = 32'hFFFF_FC00;
    run_phase(5'd31, 16'hFFFF, 16'hFFFF, 8'd3, 8'd10, 8'd2, 20);
    run_phase(5'd1, 16'd100, 16'd140, 8'd22, 8'd23, 8'd4, 20);
    repeat (2) begin
      lo_pick = 16'($urandom_range(50, 400));
      run_phase(5'($urandom_range(1, 16)), lo_pick, lo_pick + 16'($urandom_range(0, 200)),
                8'($urandom_range(0, 30)), 8'($urandom_range(0, 40)),
                8'($urandom_range(0, 8)), 20);
    end
    run_phase(RST_FRAME_BITS, RST_HB_MIN, RST_HB_MAX, RST_SEND_GAP, RST_NO_ANSWER,
              RST_STOP_GAP, 10);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
